// ===== src/tmpq_pkg.sv =====
// Shared types and constants for the timed message priority queue.
// No dependencies; imported by every module of the block.
package tmpq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_TICK_BITS   = 48;

   localparam int LIMIT_W    = 5;
   localparam int COUNT_W    = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 5'd16;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LIMIT = 1'b0;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [2:0] {
      ST_PUSHED    = 3'd0,
      ST_FULL      = 3'd1,
      ST_POPPED    = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_NOT_READY = 3'd4
   } rsp_status_type;

   typedef enum logic [0:0] {
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

// ===== src/timed_message_priority_queue_core.sv =====
// Timed message priority queue: a request is accepted when start is high and
// busy is low; its result word strobes on rsp_valid for one cycle, once the
// execute state has passed and rsp_valid is registered. busy is high for the one
// execute cycle, in which the compare-and-shift cell row updates, so no new request is taken then.
// Reset empties the queue and sets queue_limit to 16; entry cells are not
// cleared. Results cannot be stalled by the receiver.
module timed_message_priority_queue_core #(
   parameter int QUEUE_DEPTH = tmpq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TICK_BITS   = tmpq_pkg::DEFAULT_TICK_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [31:0]                      req_src_shard,
   input  logic [31:0]                      req_dst_shard,
   input  logic [63:0]                      req_msg_id,
   input  logic [63:0]                      req_task_id,
   input  logic [TICK_BITS-1:0]             req_due_tick,
   input  logic [31:0]                      req_payload_handle,
   input  logic [31:0]                      req_payload_bytes,
   input  logic [TICK_BITS-1:0]             req_now,
   // result channel
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_status,
   output logic [31:0]                      rsp_out_src_shard,
   output logic [31:0]                      rsp_out_dst_shard,
   output logic [63:0]                      rsp_out_msg_id,
   output logic [63:0]                      rsp_out_task_id,
   output logic [TICK_BITS-1:0]             rsp_out_due_tick,
   output logic [31:0]                      rsp_out_payload_handle,
   output logic [31:0]                      rsp_out_payload_bytes,
   output logic [tmpq_pkg::COUNT_W-1:0]     rsp_occupancy,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tmpq_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tmpq_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tmpq_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import tmpq_pkg::*;

   dp_cmd_type          cmd;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [CSR_IDX_W-1:0] csr_idx_w;
   logic                csr_write_w;

   assign pready      = 1'b1;
   assign csr_idx_w   = paddr[CSR_ADDR_W-1:2];
   assign csr_write_w = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_w && csr_idx_w == CSR_IDX_LIMIT) begin
         limit_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_idx_w)
         CSR_IDX_LIMIT: prdata = CSR_DATA_W'(limit_ff);
         default:       prdata = '0;
      endcase
   end

   tmpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   tmpq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TICK_BITS   (TICK_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .limit                  (limit_ff),
      .req_type               (req_type),
      .req_src_shard          (req_src_shard),
      .req_dst_shard          (req_dst_shard),
      .req_msg_id             (req_msg_id),
      .req_task_id            (req_task_id),
      .req_due_tick           (req_due_tick),
      .req_payload_handle     (req_payload_handle),
      .req_payload_bytes      (req_payload_bytes),
      .req_now                (req_now),
      .rsp_status             (rsp_status),
      .rsp_out_src_shard      (rsp_out_src_shard),
      .rsp_out_dst_shard      (rsp_out_dst_shard),
      .rsp_out_msg_id         (rsp_out_msg_id),
      .rsp_out_task_id        (rsp_out_task_id),
      .rsp_out_due_tick       (rsp_out_due_tick),
      .rsp_out_payload_handle (rsp_out_payload_handle),
      .rsp_out_payload_bytes  (rsp_out_payload_bytes),
      .rsp_occupancy          (rsp_occupancy)
   );

endmodule

// ===== src/tmpq_ctrl.sv =====
// Sequencer of the timed message priority queue: accepts a request and
// steps the datapath through one execute cycle. Depends on tmpq_pkg.
module tmpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output tmpq_pkg::dp_cmd_type cmd,
   output logic                rsp_valid
);
   import tmpq_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (start) state_in = CTL_EXEC;
         end
         CTL_EXEC: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            cmd.capture = start;
         end
         CTL_EXEC: begin
            cmd.execute = 1'b1;
            busy        = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.execute;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == CTL_EXEC)
      else $error("accepted request did not enter execute");

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == CTL_EXEC && state_ff == CTL_IDLE)
      else $error("result strobe without a preceding execute cycle");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe lasted more than one cycle");

endmodule

// ===== src/tmpq_datapath.sv =====
// Datapath of the timed message priority queue: a row of sorted entry cells
// with compare-and-shift insert, head pop, request and result registers.
// Depends on tmpq_pkg; driven by tmpq_ctrl commands.
module tmpq_datapath #(
   parameter int QUEUE_DEPTH = tmpq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TICK_BITS   = tmpq_pkg::DEFAULT_TICK_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tmpq_pkg::dp_cmd_type          cmd,
   input  logic [tmpq_pkg::LIMIT_W-1:0]  limit,
   input  logic                          req_type,
   input  logic [31:0]                   req_src_shard,
   input  logic [31:0]                   req_dst_shard,
   input  logic [63:0]                   req_msg_id,
   input  logic [63:0]                   req_task_id,
   input  logic [TICK_BITS-1:0]          req_due_tick,
   input  logic [31:0]                   req_payload_handle,
   input  logic [31:0]                   req_payload_bytes,
   input  logic [TICK_BITS-1:0]          req_now,
   output logic [2:0]                    rsp_status,
   output logic [31:0]                   rsp_out_src_shard,
   output logic [31:0]                   rsp_out_dst_shard,
   output logic [63:0]                   rsp_out_msg_id,
   output logic [63:0]                   rsp_out_task_id,
   output logic [TICK_BITS-1:0]          rsp_out_due_tick,
   output logic [31:0]                   rsp_out_payload_handle,
   output logic [31:0]                   rsp_out_payload_bytes,
   output logic [tmpq_pkg::COUNT_W-1:0]  rsp_occupancy
);
   import tmpq_pkg::*;

   localparam int SIZE_LSB   = 0;
   localparam int HANDLE_LSB = SIZE_LSB + 32;
   localparam int TICK_LSB   = HANDLE_LSB + 32;
   localparam int TASK_LSB   = TICK_LSB + TICK_BITS;
   localparam int ID_LSB     = TASK_LSB + 64;
   localparam int DST_LSB    = ID_LSB + 64;
   localparam int SRC_LSB    = DST_LSB + 32;
   localparam int ENTRY_W    = SRC_LSB + 32;

   // request registers
   logic                 req_type_ff;
   logic [ENTRY_W-1:0]   req_entry_ff;
   logic [TICK_BITS-1:0] req_now_ff;

   // entry cells, kept sorted from the head at cell 0
   logic [ENTRY_W-1:0]   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] ins_w;

   logic [COUNT_W-1:0]   count_ff, count_in;
   rsp_status_type       status_ff, status_in;
   logic                 full_w, do_insert, do_remove;

   logic [31:0]          out_src_ff, out_dst_ff, out_handle_ff, out_size_ff;
   logic [63:0]          out_id_ff, out_task_ff;
   logic [TICK_BITS-1:0] out_tick_ff;

   logic [TICK_BITS-1:0] new_tick_w, head_tick_w;
   logic [63:0]          new_id_w;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff  <= req_type;
         req_now_ff   <= req_now;
         req_entry_ff <= {req_src_shard, req_dst_shard, req_msg_id, req_task_id,
                          req_due_tick, req_payload_handle, req_payload_bytes};
      end
   end

   assign new_tick_w  = req_entry_ff[TICK_LSB +: TICK_BITS];
   assign new_id_w    = req_entry_ff[ID_LSB +: 64];
   assign head_tick_w = slot_ff[0][TICK_LSB +: TICK_BITS];

   assign full_w = (count_ff >= limit) || (32'(count_ff) >= 32'(QUEUE_DEPTH));

   always_comb begin
      status_in = ST_EMPTY;
      count_in  = count_ff;
      do_insert = 1'b0;
      do_remove = 1'b0;
      case (req_type_ff)
         REQ_PUSH: begin
            if (full_w) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_PUSHED;
               count_in  = count_ff + 5'd1;
               do_insert = 1'b1;
            end
         end
         default: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (head_tick_w > req_now_ff) begin
               status_in = ST_NOT_READY;
            end else begin
               status_in = ST_POPPED;
               count_in  = count_ff - 5'd1;
               do_remove = 1'b1;
            end
         end
      endcase
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam logic [31:0] CELL_IDX = 32'(i);

      logic [ENTRY_W-1:0]   below_w, above_w, slot_in;
      logic [TICK_BITS-1:0] cell_tick_w;
      logic [63:0]          cell_id_w;
      logic                 prev_ins_w;

      assign cell_tick_w = slot_ff[i][TICK_LSB +: TICK_BITS];
      assign cell_id_w   = slot_ff[i][ID_LSB +: 64];

      // new word goes at or before this cell if empty or it sorts ahead
      assign ins_w[i] = (CELL_IDX >= 32'(count_ff)) || (new_tick_w < cell_tick_w) ||
                        ((new_tick_w == cell_tick_w) && (new_id_w < cell_id_w));

      if (i == 0) begin : g_head
         assign prev_ins_w = 1'b0;
         assign below_w    = req_entry_ff;
      end else begin : g_body
         assign prev_ins_w = ins_w[i-1];
         assign below_w    = slot_ff[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign above_w = slot_ff[i];
      end else begin : g_inner
         assign above_w = slot_ff[i+1];
      end

      always_comb begin
         slot_in = slot_ff[i];
         if (do_insert) begin
            if (ins_w[i]) slot_in = prev_ins_w ? below_w : req_entry_ff;
         end else if (do_remove) begin
            slot_in = above_w;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.execute) slot_ff[i] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         if (do_remove) begin
            out_src_ff    <= slot_ff[0][SRC_LSB +: 32];
            out_dst_ff    <= slot_ff[0][DST_LSB +: 32];
            out_id_ff     <= slot_ff[0][ID_LSB +: 64];
            out_task_ff   <= slot_ff[0][TASK_LSB +: 64];
            out_tick_ff   <= head_tick_w;
            out_handle_ff <= slot_ff[0][HANDLE_LSB +: 32];
            out_size_ff   <= slot_ff[0][SIZE_LSB +: 32];
         end else begin
            out_src_ff    <= '0;
            out_dst_ff    <= '0;
            out_id_ff     <= '0;
            out_task_ff   <= '0;
            out_tick_ff   <= '0;
            out_handle_ff <= '0;
            out_size_ff   <= '0;
         end
      end
   end

   assign rsp_status             = status_ff;
   assign rsp_out_src_shard      = out_src_ff;
   assign rsp_out_dst_shard      = out_dst_ff;
   assign rsp_out_msg_id         = out_id_ff;
   assign rsp_out_task_id        = out_task_ff;
   assign rsp_out_due_tick       = out_tick_ff;
   assign rsp_out_payload_handle = out_handle_ff;
   assign rsp_out_payload_bytes  = out_size_ff;
   assign rsp_occupancy          = count_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(QUEUE_DEPTH))
      else $error("occupancy beyond built depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && req_type_ff == REQ_PUSH && !full_w
      |=> count_ff == $past(count_ff) + 5'd1 && status_ff == ST_PUSHED)
      else $error("accepted push did not grow the queue");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && req_type_ff == REQ_POP && count_ff == '0
      |=> status_ff == ST_EMPTY && count_ff == '0)
      else $error("pop on empty queue misreported");

   a_not_ready_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && req_type_ff == REQ_POP && count_ff != '0 && head_tick_w > req_now_ff
      |=> status_ff == ST_NOT_READY && $stable(count_ff))
      else $error("pop of a future head changed the queue");

endmodule
